@@ rtl/core/max_island_area_macros.svh @@
// Assertion macros for the max_island_area RTL, used by the walker.
`ifndef MAX_ISLAND_AREA_MACROS_SVH
`define MAX_ISLAND_AREA_MACROS_SVH

// Assert that an implication holds at every clock edge outside reset.
`define MIA_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Assert that an implication holds in the cycle after its antecedent.
`define MIA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

@@ rtl/core/mia_pkg.sv @@
// Package with the shared types and constants of max_island_area.
`timescale 1ns / 1ps
package mia_pkg;
  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int CellCap = MaxRows * MaxCols;
  localparam int IdxW = $clog2(CellCap);
  localparam int CntW = $clog2(CellCap + 1);
  localparam int RowW = $clog2(MaxRows + 1);
  localparam int ColW = $clog2(MaxCols + 1);
  localparam int AreaW = 13;
  localparam int CfgW = 7;
  localparam int AreaMax = 8191;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  // Job handed from the loader to the walker: the geometry of a loaded grid.
  typedef struct packed {
    logic [RowW-1:0] rows;
    logic [ColW-1:0] cols;
    logic [CntW-1:0] total;
  } job_t;
endpackage

@@ rtl/core/mia_front.sv @@
// Loader: stores grid cells in raster order and posts a walk job per full grid.
`timescale 1ns / 1ps
module mia_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    cell_req_i,
  input  logic                    abort_i,
  input  logic [mia_pkg::RowW-1:0] rows_i,
  input  logic [mia_pkg::ColW-1:0] cols_i,
  input  logic                    busy_i,
  output logic                    cell_we_o,
  output logic [mia_pkg::IdxW-1:0] cell_addr_o,
  output logic                    cell_dat_o,
  output logic                    job_vld_o,
  output mia_pkg::job_t           job_o
);
  import mia_pkg::*;

  logic [CntW-1:0] load_q, load_d;
  logic [CntW-1:0] total;
  logic            take;

  assign total = CntW'(rows_i) * CntW'(cols_i);
  assign take = start_i && !busy_i;

  // Count cells of the current grid; a config write restarts it.
  always_comb begin
    load_d = load_q;
    if (abort_i) begin
      load_d = '0;
    end else if (take) begin
      load_d = (load_q + 1'b1 >= total) ? '0 : load_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else begin
      load_q <= load_d;
    end
  end

  assign cell_we_o = take;
  assign cell_addr_o = load_q[IdxW-1:0];
  assign cell_dat_o = cell_req_i;
  assign job_vld_o = take && (load_q + 1'b1 >= total);
  assign job_o = '{rows: rows_i, cols: cols_i, total: total};
endmodule

@@ rtl/core/mia_back.sv @@
// Walker: flood fills the stored grid with an explicit stack and a seen map.
`timescale 1ns / 1ps
module mia_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cell_we_i,
  input  logic [mia_pkg::IdxW-1:0]  cell_addr_i,
  input  logic                      cell_dat_i,
  input  logic                      job_vld_i,
  input  mia_pkg::job_t             job_i,
  output logic                      idle_o,
  output logic                      done_o,
  output logic [mia_pkg::AreaW-1:0] island_area_o
);
  import mia_pkg::*;
  `include "max_island_area_macros.svh"

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_SCANR = 9'b000001000,
    S_POP   = 9'b000010000,
    S_POPR  = 9'b000100000,
    S_NBR   = 9'b001000000,
    S_NBRR  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  // Stack entry: a cell index together with its row and column.
  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } stk_ent_t;

  logic cell_mem [CellCap];
  logic seen_mem [CellCap];
  stk_ent_t stk_mem [CellCap];

  state_e          st_q, st_d;
  job_t            job_q, job_d;
  logic [CntW-1:0] ptr_q, ptr_d;      // clear pointer and scan index
  logic [CntW-1:0] sp_q, sp_d;        // stack depth
  logic [IdxW-1:0] cur_q, cur_d;      // cell being expanded
  logic [RowW-1:0] r_q, r_d;
  logic [ColW-1:0] c_q, c_d;
  logic [RowW-1:0] sr_q, sr_d;        // row/col tracked during scan
  logic [ColW-1:0] sc_q, sc_d;
  logic [2:0]      dir_q, dir_d;
  logic [IdxW-1:0] nb_q, nb_d;        // neighbor being tested
  logic [RowW-1:0] nbr_q, nbr_d;
  logic [ColW-1:0] nbc_q, nbc_d;
  logic [CntW-1:0] grp_q, grp_d;
  logic [CntW-1:0] best_q, best_d;

  // Memory port control.
  logic            rd_addr_unused_n;
  logic [IdxW-1:0] rd_addr;
  logic            cell_rq, seen_rq;
  logic            seen_we, seen_wd;
  logic [IdxW-1:0] seen_wa;
  logic            stk_we;
  logic [IdxW-1:0] stk_wa, stk_ra;
  stk_ent_t        stk_wd, stk_rq;
  logic            nb_ok;
  logic [IdxW-1:0] nb_idx;
  logic [RowW-1:0] nb_r;
  logic [ColW-1:0] nb_c;

  assign rd_addr_unused_n = 1'b1;

  // Cell store: written by the loader, read by the walker.
  always_ff @(posedge clk_i) begin
    if (cell_we_i) begin
      cell_mem[cell_addr_i] <= cell_dat_i;
    end
    cell_rq <= cell_mem[rd_addr];
  end

  // Seen map, cleared per grid by a sweep.
  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    seen_rq <= seen_mem[rd_addr];
  end

  // Walk stack.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rq <= stk_mem[stk_ra];
  end

  // Neighbor selection for the current cell: down, up, right, left.
  always_comb begin
    nb_ok = 1'b0;
    nb_idx = cur_q;
    nb_r = r_q;
    nb_c = c_q;
    case (dir_q)
      3'd0: begin
        nb_ok = (RowW'(r_q + 1'b1) < job_q.rows);
        nb_idx = cur_q + IdxW'(job_q.cols);
        nb_r = RowW'(r_q + 1'b1);
      end
      3'd1: begin
        nb_ok = (r_q != '0);
        nb_idx = cur_q - IdxW'(job_q.cols);
        nb_r = RowW'(r_q - 1'b1);
      end
      3'd2: begin
        nb_ok = (ColW'(c_q + 1'b1) < job_q.cols);
        nb_idx = cur_q + 1'b1;
        nb_c = ColW'(c_q + 1'b1);
      end
      3'd3: begin
        nb_ok = (c_q != '0);
        nb_idx = cur_q - 1'b1;
        nb_c = ColW'(c_q - 1'b1);
      end
      default: begin
        nb_ok = 1'b0;
        nb_idx = cur_q;
      end
    endcase
  end

  // Walk sequencer.
  always_comb begin
    st_d = st_q;
    job_d = job_q;
    ptr_d = ptr_q;
    sp_d = sp_q;
    cur_d = cur_q;
    r_d = r_q;
    c_d = c_q;
    sr_d = sr_q;
    sc_d = sc_q;
    dir_d = dir_q;
    nb_d = nb_q;
    nbr_d = nbr_q;
    nbc_d = nbc_q;
    grp_d = grp_q;
    best_d = best_q;
    rd_addr = ptr_q[IdxW-1:0];
    seen_we = 1'b0;
    seen_wd = 1'b0;
    seen_wa = ptr_q[IdxW-1:0];
    stk_we = 1'b0;
    stk_wa = sp_q[IdxW-1:0];
    stk_ra = IdxW'(sp_q - 1'b1);
    stk_wd = '{idx: ptr_q[IdxW-1:0], row: sr_q, col: sc_q};
    done_o = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (job_vld_i) begin
          job_d = job_i;
          ptr_d = '0;
          st_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        seen_we = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q + 1'b1 >= job_q.total) begin
          ptr_d = '0;
          sr_d = '0;
          sc_d = '0;
          best_d = '0;
          st_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (ptr_q >= job_q.total) begin
          st_d = S_DONE;
        end else begin
          rd_addr = ptr_q[IdxW-1:0];
          st_d = S_SCANR;
        end
      end
      S_SCANR: begin
        if (cell_rq && !seen_rq) begin
          // New group: mark and push the seed with its scan position.
          rd_addr = ptr_q[IdxW-1:0];
          seen_we = 1'b1;
          seen_wd = 1'b1;
          stk_we = 1'b1;
          sp_d = CntW'(1);
          grp_d = '0;
          st_d = S_POP;
        end else begin
          st_d = S_SCAN;
        end
        ptr_d = ptr_q + 1'b1;
        if (ColW'(sc_q + 1'b1) >= job_q.cols) begin
          sc_d = '0;
          sr_d = sr_q + 1'b1;
        end else begin
          sc_d = sc_q + 1'b1;
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          if (grp_q > best_q) begin
            best_d = grp_q;
          end
          st_d = S_SCAN;
        end else begin
          sp_d = sp_q - 1'b1;
          st_d = S_POPR;
        end
      end
      S_POPR: begin
        // Stack data now valid; load the cell with its row and column.
        cur_d = stk_rq.idx;
        r_d = stk_rq.row;
        c_d = stk_rq.col;
        grp_d = grp_q + 1'b1;
        dir_d = '0;
        st_d = S_NBR;
      end
      S_NBR: begin
        if (dir_q == 3'd4) begin
          st_d = S_POP;
        end else if (nb_ok) begin
          rd_addr = nb_idx;
          nb_d = nb_idx;
          nbr_d = nb_r;
          nbc_d = nb_c;
          st_d = S_NBRR;
        end else begin
          dir_d = dir_q + 1'b1;
        end
      end
      S_NBRR: begin
        rd_addr = nb_q;
        if (cell_rq && !seen_rq) begin
          seen_we = 1'b1;
          seen_wd = 1'b1;
          seen_wa = nb_q;
          stk_we = 1'b1;
          stk_wd = '{idx: nb_q, row: nbr_q, col: nbc_q};
          sp_d = sp_q + 1'b1;
        end
        dir_d = dir_q + 1'b1;
        st_d = S_NBR;
      end
      S_DONE: begin
        done_o = 1'b1;
        st_d = S_IDLE;
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      ptr_q <= '0;
      sp_q <= '0;
      grp_q <= '0;
      best_q <= '0;
      dir_q <= '0;
    end else begin
      st_q <= st_d;
      ptr_q <= ptr_d;
      sp_q <= sp_d;
      grp_q <= grp_d;
      best_q <= best_d;
      dir_q <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    cur_q <= cur_d;
    nb_q <= nb_d;
    nbr_q <= nbr_d;
    nbc_q <= nbc_d;
    sr_q <= sr_d;
    sc_q <= sc_d;
    r_q <= r_d;
    c_q <= c_d;
  end

  assign idle_o = (st_q == S_IDLE) && rd_addr_unused_n;
  assign island_area_o = (best_q > CntW'(AreaMax)) ? AreaW'(AreaMax) : AreaW'(best_q);

  `MIA_ASSERT_IMPL(a_done_from_done, clk_i, rst_ni, done_o, st_q == S_DONE)
  `MIA_ASSERT_NEXT(a_done_to_idle, clk_i, rst_ni, st_q == S_DONE, st_q == S_IDLE)
  `MIA_ASSERT_IMPL(a_stack_bound, clk_i, rst_ni, 1'b1, sp_q <= CntW'(CellCap))
endmodule

@@ rtl/core/max_island_area.sv @@
// Top level of max_island_area: register file, loader and walker.
//
// Channel   Direction  Handshake
// cell      in         start && !busy accepts cell_req_i
// result    out        done strobe, one cycle, island_area_o
// config    in         cfg_we_i with cfg_idx_i and cfg_data_i
//
// Loading takes one cell per cycle while busy is low. After the last cell the
// walker clears the seen map, scans every cell, and on each land cell does a
// pop and four neighbor checks; the done strobe comes in the cycle after the
// scan ends. busy holds off start from the last cell through the strobe
// cycle; the result strobe cannot be stalled. Reset restores 64 x 64 and an
// empty grid.
`timescale 1ns / 1ps
module max_island_area (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cell_req_i,
  output logic                        done,
  output logic [mia_pkg::AreaW-1:0]   island_area_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [mia_pkg::CfgW-1:0]    cfg_data_i
);
  import mia_pkg::*;

  logic [CfgW-1:0] rows_q, cols_q;
  logic [RowW-1:0] rows_c;
  logic [ColW-1:0] cols_c;
  logic            cell_we, cell_dat, job_vld, idle;
  logic [IdxW-1:0] cell_addr;
  job_t            job;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= CfgW'(64);
      cols_q <= CfgW'(64);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgRows) begin
        rows_q <= cfg_data_i;
      end else begin
        cols_q <= cfg_data_i;
      end
    end
  end

  // Clamp sizes into range.
  assign rows_c = (rows_q == '0) ? RowW'(1) :
                  (rows_q > CfgW'(MaxRows)) ? RowW'(MaxRows) : RowW'(rows_q);
  assign cols_c = (cols_q == '0) ? ColW'(1) :
                  (cols_q > CfgW'(MaxCols)) ? ColW'(MaxCols) : ColW'(cols_q);

  assign busy = !idle;

  mia_front u_front (
    .clk_i, .rst_ni, .start_i(start), .cell_req_i,
    .abort_i(cfg_we_i), .rows_i(rows_c), .cols_i(cols_c), .busy_i(busy),
    .cell_we_o(cell_we), .cell_addr_o(cell_addr), .cell_dat_o(cell_dat),
    .job_vld_o(job_vld), .job_o(job)
  );

  mia_back u_back (
    .clk_i, .rst_ni, .cell_we_i(cell_we), .cell_addr_i(cell_addr),
    .cell_dat_i(cell_dat), .job_vld_i(job_vld), .job_i(job),
    .idle_o(idle), .done_o(done), .island_area_o
  );
endmodule

@@ tb/sv/max_island_area_checker.sv @@
// Checker for max_island_area: predicts the largest island of each grid and compares.
`timescale 1ns / 1ps
module max_island_area_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       cell_req_i,
  input  logic                       done,
  input  logic [mia_pkg::AreaW-1:0]  island_area_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [mia_pkg::CfgW-1:0]   cfg_data_i,
  output int                         fail_count_o,
  output int                         pending_o
);
  import mia_pkg::*;

  logic [CfgW-1:0]  rows_reg;
  logic [CfgW-1:0]  cols_reg;
  int               cells_loaded;
  logic             land [CellCap];
  logic             visited [CellCap];
  int               fill_stack [CellCap];
  logic [AreaW-1:0] area_queue [$];

  // Sizes outside the legal range are pulled to the nearest legal value.
  function automatic int legal_size(logic [CfgW-1:0] v, int hi);
    if (v == 0) return 1;
    return (int'(v) > hi) ? hi : int'(v);
  endfunction

  // Flood-fill every island of the loaded grid and return the largest area.
  function automatic logic [AreaW-1:0] largest_island(int nrows, int ncols);
    int best;
    int area;
    int top;
    int idx;
    int r;
    int c;
    int nb [4];
    bit ok [4];
    best = 0;
    for (int i = 0; i < CellCap; i++) visited[i] = 1'b0;
    for (int s = 0; s < nrows * ncols; s++) begin
      if (!land[s] || visited[s]) continue;
      area = 0;
      top = 1;
      fill_stack[0] = s;
      visited[s] = 1'b1;
      while (top > 0) begin
        top--;
        idx = fill_stack[top];
        r = idx / ncols;
        c = idx % ncols;
        area++;
        nb[0] = idx + ncols; ok[0] = (r + 1 < nrows);
        nb[1] = idx - ncols; ok[1] = (r > 0);
        nb[2] = idx + 1;     ok[2] = (c + 1 < ncols);
        nb[3] = idx - 1;     ok[3] = (c > 0);
        for (int k = 0; k < 4; k++) begin
          if (ok[k] && land[nb[k]] && !visited[nb[k]]) begin
            visited[nb[k]] = 1'b1;
            fill_stack[top] = nb[k];
            top++;
          end
        end
      end
      if (area > best) best = area;
    end
    return (best > AreaMax) ? AreaW'(AreaMax) : AreaW'(best);
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] area check: %s", $realtime, what);
    fail_count_o++;
  endtask

  // Track configuration, accepted words and result strobes at each edge.
  always @(posedge clk_i or negedge rst_ni) begin
    int nrows;
    int ncols;
    logic [AreaW-1:0] want;
    if (!rst_ni) begin
      rows_reg <= CfgW'(MaxRows);
      cols_reg <= CfgW'(MaxCols);
      cells_loaded = 0;
      area_queue.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgRows) rows_reg <= cfg_data_i;
        else cols_reg <= cfg_data_i;
        cells_loaded = 0;
      end
      if (start && !busy) begin
        nrows = legal_size(rows_reg, MaxRows);
        ncols = legal_size(cols_reg, MaxCols);
        land[cells_loaded] = cell_req_i;
        cells_loaded++;
        if (cells_loaded >= nrows * ncols) begin
          area_queue.push_back(largest_island(nrows, ncols));
          cells_loaded = 0;
        end
      end
      if (done) begin
        if (area_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", island_area_o));
        end else begin
          want = area_queue.pop_front();
          if (island_area_o !== want)
            report_mismatch($sformatf("area got %0d want %0d", island_area_o, want));
        end
      end
      pending_o <= area_queue.size();
    end
  end

  initial fail_count_o = 0;
endmodule

@@ tb/sv/max_island_area_tb.sv @@
// Testbench top for max_island_area: stimulus, timeout and verdict.
`timescale 1ns / 1ps
module max_island_area_tb;
  import mia_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int RandomCells = 300;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cell_req_i;
  logic               done;
  logic [AreaW-1:0]   island_area_o;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [CfgW-1:0]    cfg_data_i;
  int                 fail_count;
  int                 pending_areas;
  int                 cycle_count;
  int                 idle_pct;
  int                 cells_sent;
  logic [CfgW-1:0]    rows_set;
  logic [CfgW-1:0]    cols_set;

  max_island_area dut (.*);

  max_island_area_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .cell_req_i, .done, .island_area_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending_areas)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Offer one cell word, with random idle cycles first, and wait for acceptance.
  task automatic send_cell(logic v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cell_req_i <= v;
    do @(posedge clk_i); while (busy);
    cells_sent++;
  endtask

  // Write a register once the block is idle and every result has arrived.
  task automatic write_reg(logic idx, logic [CfgW-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_areas != 0 || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgRows) rows_set = value;
    else cols_set = value;
  endtask

  task automatic set_size(logic [CfgW-1:0] r, logic [CfgW-1:0] c);
    write_reg(CfgRows, r);
    write_reg(CfgCols, c);
  endtask

  function automatic int eff(logic [CfgW-1:0] v, int hi);
    return (v == 0) ? 1 : ((int'(v) > hi) ? hi : int'(v));
  endfunction

  // Send a whole grid; density is the percent chance of land per cell.
  task automatic send_grid(int density);
    int total;
    total = eff(rows_set, MaxRows) * eff(cols_set, MaxCols);
    for (int i = 0; i < total; i++) send_cell($urandom_range(99) < density);
  endtask

  task automatic send_bits(string bits);
    for (int i = 0; i < bits.len(); i++) send_cell(bits[i] == "1");
  endtask

  // Mostly small sizes, sometimes zero.
  function automatic logic [CfgW-1:0] pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 5) return '0;
    return CfgW'($urandom_range(1, 8));
  endfunction

  initial begin
    int p;
    rst_ni = 1'b0;
    start = 1'b0;
    cell_req_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgRows;
    cfg_data_i = '0;
    cycle_count = 0;
    cells_sent = 0;
    idle_pct = 26;
    rows_set = CfgW'(MaxRows);
    cols_set = CfgW'(MaxCols);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single cells, diagonal contact, no wrap, clamped size, abandon.
    set_size(1, 1);
    send_bits("0");
    send_bits("1");
    set_size(2, 2);
    send_bits("1001");
    send_bits("1101");
    set_size(0, 3);
    send_bits("101");
    set_size(2, 3);
    send_bits("001100");
    send_bits("10");
    write_reg(CfgCols, 3);
    send_bits("111111");

    // Random grids over three idling phases; long thin grids reach the maximum
    // and out-of-range sizes while keeping the cell count small.
    cells_sent = 0;
    while (cells_sent < RandomCells) begin
      idle_pct = (cells_sent < RandomCells / 3) ? 26 :
                 (cells_sent < 2 * RandomCells / 3) ? 67 : 0;
      if ($urandom_range(2) == 0 || rows_set > 8 || cols_set > 8 ||
          rows_set == 0 || cols_set == 0) begin
        p = $urandom_range(99);
        if (p < 4) begin
          set_size(CfgW'($urandom_range(64, 127)), CfgW'($urandom_range(0, 2)));
        end else if (p < 8) begin
          set_size(CfgW'($urandom_range(0, 2)), CfgW'($urandom_range(64, 127)));
        end else begin
          set_size(pick_size(), pick_size());
        end
      end
      send_grid($urandom_range(100));
      if (idle_pct == 0 && $urandom_range(3) == 0) begin
        start <= 1'b0;
        @(posedge clk_i);
        while (pending_areas != 0) @(posedge clk_i);
      end
    end

    // Full-height column of land, then a full-width strip of random land.
    idle_pct = 0;
    set_size(127, 1);
    send_grid(100);
    set_size(2, 64);
    send_grid(60);
    start <= 1'b0;

    @(posedge clk_i);
    while (pending_areas != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
